FILE: hdl/dlut_pkg.sv
`default_nettype none
package dlut_pkg;

  localparam int CMD_W  = 16;
  localparam int DUTY_W = 10;
  localparam int IDX_W  = 4;
  localparam int ADDR_W = 2 * IDX_W;
  localparam int MAP_DEPTH = 1 << ADDR_W;
  localparam int CFG_IDX_W = 3;
  localparam int BP_W   = 18;
  localparam int Z_W    = 12;
  localparam int NUM_W  = 30;
  localparam int DEN_W  = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_X_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_X_CELLS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_CELLS = 3'd5;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLASS, ST_QSTART, ST_QWAIT, ST_SRCH,
    ST_READ, ST_LMUL, ST_LDIV, ST_LWAIT, ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    M_CORNER, M_XEDGE, M_YEDGE, M_INSIDE
  } mode_t;

endpackage
`default_nettype wire

FILE: hdl/duty_map_bilinear_lookup.sv
// channel | direction | handshake          | payload
// in      | input     | start, busy        | kind, entry_row/col/value, command_x/y
// out     | output    | out_strobe         | duty_value, one beat per evaluate
// cfg     | input     | cfg_we, cfg_index  | cfg_wdata
// A load beat writes the map RAM in its accept cycle and leaves busy low.
// An evaluate beat keeps busy high for its whole run and strobes in the cycle after:
// per searched axis one pass of the shared radix-2 divider (start, one quotient bit per
// step, done) plus a search over up to 15 cells, up to four RAM reads, and one multiply
// and divide per interpolation (three for an inner point).
// rst_n is synchronous; the map RAM is not cleared. The receiver cannot stall.
`default_nettype none
module duty_map_bilinear_lookup (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                in_kind,
  input  wire logic [dlut_pkg::IDX_W-1:0]          in_entry_row,
  input  wire logic [dlut_pkg::IDX_W-1:0]          in_entry_col,
  input  wire logic [dlut_pkg::DUTY_W-1:0]         in_entry_value,
  input  wire logic signed [dlut_pkg::CMD_W-1:0]   in_command_x,
  input  wire logic signed [dlut_pkg::CMD_W-1:0]   in_command_y,
  output logic                                     out_strobe,
  output logic [dlut_pkg::DUTY_W-1:0]              out_duty_value,
  input  wire logic                                cfg_we,
  input  wire logic [dlut_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [dlut_pkg::CMD_W-1:0]          cfg_wdata
);

  localparam int CW = dlut_pkg::CMD_W;
  localparam int IW = dlut_pkg::IDX_W;
  localparam int BW = dlut_pkg::BP_W;
  localparam int ZW = dlut_pkg::Z_W;
  localparam int DW = dlut_pkg::DUTY_W;
  localparam int NW = dlut_pkg::NUM_W;
  localparam int EW = dlut_pkg::DEN_W;

  // configuration
  logic signed [CW-1:0] xlo_lim_r, xhi_lim_r, ylo_lim_r, yhi_lim_r;
  logic [IW-1:0]        xcells_r, ycells_r;
  logic [IW-1:0]        nx, ny;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xlo_lim_r <= 16'sd0;
      xhi_lim_r <= 16'sd1000;
      ylo_lim_r <= 16'sd0;
      yhi_lim_r <= 16'sd1000;
      xcells_r  <= 4'd1;
      ycells_r  <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dlut_pkg::CFG_X_LOW:   xlo_lim_r <= cfg_wdata;
        dlut_pkg::CFG_X_HIGH:  xhi_lim_r <= cfg_wdata;
        dlut_pkg::CFG_Y_LOW:   ylo_lim_r <= cfg_wdata;
        dlut_pkg::CFG_Y_HIGH:  yhi_lim_r <= cfg_wdata;
        dlut_pkg::CFG_X_CELLS: xcells_r  <= cfg_wdata[IW-1:0];
        dlut_pkg::CFG_Y_CELLS: ycells_r  <= cfg_wdata[IW-1:0];
        default: ;
      endcase
    end
  end

  assign nx = (xcells_r == '0) ? IW'(1) : xcells_r;
  assign ny = (ycells_r == '0) ? IW'(1) : ycells_r;

  // state
  dlut_pkg::state_t     state_r, state_nxt;
  dlut_pkg::mode_t      mode_r, mode_nxt;
  logic                 ax_r, ax_nxt;
  logic signed [CW-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [IW-1:0]        rf_r, rf_nxt, cf_r, cf_nxt;
  logic [IW-1:0]        i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic signed [BW-1:0] xb0_r, xb0_nxt, xb1_r, xb1_nxt;
  logic signed [BW-1:0] yb0_r, yb0_nxt, yb1_r, yb1_nxt;
  logic signed [BW-1:0] bpl_r, bpl_nxt;
  logic [CW:0]          q0_r, q0_nxt, accq_r, accq_nxt;
  logic [IW-1:0]        r0_r, r0_nxt, accr_r, accr_nxt;
  logic [2:0]           rd_cnt_r, rd_cnt_nxt;
  logic [3:0][DW-1:0]   ez_r, ez_nxt;
  logic [1:0][ZW-1:0]   zr_r, zr_nxt;
  logic [1:0]           lp_r, lp_nxt;
  logic signed [NW-1:0] prod_r, prod_nxt;
  logic [DW-1:0]        res_r, res_nxt;
  logic                 out_strobe_r, out_strobe_nxt;
  logic [DW-1:0]        out_val_r, out_val_nxt;

  // divider and RAM
  logic          div_start;
  logic [NW-1:0] div_a;
  logic [EW-1:0] div_b;
  logic          div_done;
  logic [NW-1:0] div_q;
  logic [EW-1:0] div_r;

  logic [dlut_pkg::ADDR_W-1:0] raddr;
  logic [DW-1:0]               rdata;
  logic                        map_we;

  assign map_we = start && !busy && (in_kind == dlut_pkg::KIND_LOAD);

  dlut_ram #(.WIDTH(DW), .DEPTH(dlut_pkg::MAP_DEPTH)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr ({in_entry_row, in_entry_col}),
    .wdata (in_entry_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  dlut_div #(.NW(NW), .DW(EW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // classification
  logic xlo, xhi, ylo, yhi;
  assign xlo = cx_r <= xlo_lim_r;
  assign xhi = cx_r >= xhi_lim_r;
  assign ylo = cy_r <= ylo_lim_r;
  assign yhi = cy_r >= yhi_lim_r;

  // axis under search
  logic signed [CW-1:0] lo_sel, hi_sel, v_sel;
  logic [IW-1:0]        n_sel;
  logic [CW:0]          d_sel;
  logic [IW:0]          rsum;
  logic                 wrap;
  logic [IW:0]          rnew;
  logic [CW:0]          nq;
  logic signed [BW-1:0] bph;
  logic                 hit;

  assign lo_sel = ax_r ? ylo_lim_r : xlo_lim_r;
  assign hi_sel = ax_r ? yhi_lim_r : xhi_lim_r;
  assign v_sel  = ax_r ? cy_r : cx_r;
  assign n_sel  = ax_r ? ny : nx;
  assign d_sel  = {hi_sel[CW-1], hi_sel} - {lo_sel[CW-1], lo_sel};
  assign rsum   = {1'b0, accr_r} + {1'b0, r0_r};
  assign wrap   = rsum >= {1'b0, n_sel};
  assign rnew   = wrap ? (rsum - {1'b0, n_sel}) : rsum;
  assign nq     = accq_r + q0_r + (CW+1)'(wrap);
  assign bph    = BW'(lo_sel) + $signed({1'b0, nq});
  assign hit    = (BW'(v_sel) <= bph) || (k_r == n_sel - IW'(1));

  // RAM read addressing
  logic [2:0]    nreads;
  logic [1:0]    t;
  logic [IW-1:0] br, bc;
  logic          roff, coff;
  logic [2:0]    cap_idx;

  assign t  = rd_cnt_r[1:0];
  assign br = (mode_r == dlut_pkg::M_XEDGE || mode_r == dlut_pkg::M_INSIDE) ? j_r : rf_r;
  assign bc = (mode_r == dlut_pkg::M_YEDGE || mode_r == dlut_pkg::M_INSIDE) ? i_r : cf_r;
  assign roff = (mode_r == dlut_pkg::M_INSIDE) ? t[1] :
                ((mode_r == dlut_pkg::M_XEDGE) ? t[0] : 1'b0);
  assign coff = (mode_r == dlut_pkg::M_INSIDE || mode_r == dlut_pkg::M_YEDGE) ? t[0] : 1'b0;
  assign raddr = {br + IW'(roff), bc + IW'(coff)};
  assign cap_idx = rd_cnt_r - 3'd1;

  always_comb begin
    unique case (mode_r)
      dlut_pkg::M_CORNER: nreads = 3'd1;
      dlut_pkg::M_INSIDE: nreads = 3'd4;
      default:            nreads = 3'd2;
    endcase
  end

  // interpolation operands
  logic                 use_y;
  logic signed [BW-1:0] lv, lv0, lv1, dv, den;
  logic signed [ZW-1:0] lz0, lz1, dz, lq, lres;
  logic signed [NW-1:0] prod_c;
  logic [NW-1:0]        mag;
  logic                 lfin;

  assign use_y = (mode_r == dlut_pkg::M_XEDGE) ||
                 (mode_r == dlut_pkg::M_INSIDE && lp_r == 2'd2);
  assign lv  = use_y ? BW'(cy_r) : BW'(cx_r);
  assign lv0 = use_y ? yb0_r : xb0_r;
  assign lv1 = use_y ? yb1_r : xb1_r;

  always_comb begin
    if (mode_r == dlut_pkg::M_INSIDE && lp_r == 2'd2) begin
      lz0 = $signed(zr_r[0]);
      lz1 = $signed(zr_r[1]);
    end else if (mode_r == dlut_pkg::M_INSIDE && lp_r == 2'd1) begin
      lz0 = $signed({2'b00, ez_r[2]});
      lz1 = $signed({2'b00, ez_r[3]});
    end else begin
      lz0 = $signed({2'b00, ez_r[0]});
      lz1 = $signed({2'b00, ez_r[1]});
    end
  end

  assign dv     = lv - lv0;
  assign den    = lv1 - lv0;
  assign dz     = lz1 - lz0;
  assign prod_c = NW'(dz) * NW'(dv);
  assign mag    = prod_r[NW-1] ? NW'(-prod_r) : NW'(prod_r);
  assign lq     = $signed(div_q[ZW-1:0]);
  assign lres   = lz0 + (prod_r[NW-1] ? -lq : lq);
  assign lfin   = (mode_r == dlut_pkg::M_INSIDE) ? (lp_r == 2'd2) : 1'b1;

  always_comb begin
    div_start = 1'b0;
    div_a     = NW'(d_sel);
    div_b     = EW'(n_sel);
    if (state_r == dlut_pkg::ST_LDIV) begin
      div_start = 1'b1;
      div_a     = mag;
      div_b     = EW'(den);
    end else if (state_r == dlut_pkg::ST_QSTART) begin
      div_start = 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    ax_nxt         = ax_r;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    rf_nxt         = rf_r;
    cf_nxt         = cf_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    k_nxt          = k_r;
    xb0_nxt        = xb0_r;
    xb1_nxt        = xb1_r;
    yb0_nxt        = yb0_r;
    yb1_nxt        = yb1_r;
    bpl_nxt        = bpl_r;
    q0_nxt         = q0_r;
    r0_nxt         = r0_r;
    accq_nxt       = accq_r;
    accr_nxt       = accr_r;
    rd_cnt_nxt     = rd_cnt_r;
    ez_nxt         = ez_r;
    zr_nxt         = zr_r;
    lp_nxt         = lp_r;
    prod_nxt       = prod_r;
    res_nxt        = res_r;
    out_strobe_nxt = 1'b0;
    out_val_nxt    = out_val_r;

    unique case (state_r)
      dlut_pkg::ST_IDLE: begin
        if (start && (in_kind == dlut_pkg::KIND_EVAL)) begin
          cx_nxt    = in_command_x;
          cy_nxt    = in_command_y;
          state_nxt = dlut_pkg::ST_CLASS;
        end
      end
      dlut_pkg::ST_CLASS: begin
        rd_cnt_nxt = '0;
        priority if (xlo && ylo) begin
          mode_nxt = dlut_pkg::M_CORNER;
          rf_nxt = '0;
          cf_nxt = '0;
          state_nxt = dlut_pkg::ST_READ;
        end else if (xhi && ylo) begin
          mode_nxt = dlut_pkg::M_CORNER;
          rf_nxt = '0;
          cf_nxt = nx;
          state_nxt = dlut_pkg::ST_READ;
        end else if (xlo && yhi) begin
          mode_nxt = dlut_pkg::M_CORNER;
          rf_nxt = ny;
          cf_nxt = '0;
          state_nxt = dlut_pkg::ST_READ;
        end else if (xhi && yhi) begin
          mode_nxt = dlut_pkg::M_CORNER;
          rf_nxt = ny;
          cf_nxt = nx;
          state_nxt = dlut_pkg::ST_READ;
        end else if (xlo || xhi) begin
          mode_nxt = dlut_pkg::M_XEDGE;
          cf_nxt = xlo ? '0 : nx;
          ax_nxt = 1'b1;
          state_nxt = dlut_pkg::ST_QSTART;
        end else if (ylo || yhi) begin
          mode_nxt = dlut_pkg::M_YEDGE;
          rf_nxt = ylo ? '0 : ny;
          ax_nxt = 1'b0;
          state_nxt = dlut_pkg::ST_QSTART;
        end else begin
          mode_nxt = dlut_pkg::M_INSIDE;
          ax_nxt = 1'b0;
          state_nxt = dlut_pkg::ST_QSTART;
        end
      end
      dlut_pkg::ST_QSTART: begin
        state_nxt = dlut_pkg::ST_QWAIT;
      end
      dlut_pkg::ST_QWAIT: begin
        if (div_done) begin
          q0_nxt    = div_q[CW:0];
          r0_nxt    = div_r[IW-1:0];
          accq_nxt  = '0;
          accr_nxt  = '0;
          k_nxt     = '0;
          bpl_nxt   = BW'(lo_sel);
          state_nxt = dlut_pkg::ST_SRCH;
        end
      end
      dlut_pkg::ST_SRCH: begin
        if (hit) begin
          if (ax_r) begin
            j_nxt   = k_r;
            yb0_nxt = bpl_r;
            yb1_nxt = bph;
          end else begin
            i_nxt   = k_r;
            xb0_nxt = bpl_r;
            xb1_nxt = bph;
          end
          if (!ax_r && mode_r == dlut_pkg::M_INSIDE) begin
            ax_nxt    = 1'b1;
            state_nxt = dlut_pkg::ST_QSTART;
          end else begin
            state_nxt = dlut_pkg::ST_READ;
          end
        end else begin
          accq_nxt = nq;
          accr_nxt = rnew[IW-1:0];
          bpl_nxt  = bph;
          k_nxt    = k_r + IW'(1);
        end
      end
      dlut_pkg::ST_READ: begin
        if (rd_cnt_r != 3'd0) begin
          ez_nxt[cap_idx[1:0]] = rdata;
        end
        if (rd_cnt_r == nreads) begin
          lp_nxt = '0;
          if (mode_r == dlut_pkg::M_CORNER) begin
            res_nxt   = rdata;
            state_nxt = dlut_pkg::ST_FIN;
          end else begin
            state_nxt = dlut_pkg::ST_LMUL;
          end
        end else begin
          rd_cnt_nxt = rd_cnt_r + 3'd1;
        end
      end
      dlut_pkg::ST_LMUL: begin
        if (lv1 == lv0) begin
          if (lfin) begin
            res_nxt   = lz0[DW-1:0];
            state_nxt = dlut_pkg::ST_FIN;
          end else begin
            zr_nxt[lp_r[0]] = lz0;
            lp_nxt = lp_r + 2'd1;
          end
        end else begin
          prod_nxt  = prod_c;
          state_nxt = dlut_pkg::ST_LDIV;
        end
      end
      dlut_pkg::ST_LDIV: begin
        state_nxt = dlut_pkg::ST_LWAIT;
      end
      dlut_pkg::ST_LWAIT: begin
        if (div_done) begin
          if (lfin) begin
            res_nxt   = lres[DW-1:0];
            state_nxt = dlut_pkg::ST_FIN;
          end else begin
            zr_nxt[lp_r[0]] = lres;
            lp_nxt    = lp_r + 2'd1;
            state_nxt = dlut_pkg::ST_LMUL;
          end
        end
      end
      dlut_pkg::ST_FIN: begin
        out_strobe_nxt = 1'b1;
        out_val_nxt    = res_r;
        state_nxt      = dlut_pkg::ST_IDLE;
      end
      default: state_nxt = dlut_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dlut_pkg::ST_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    mode_r    <= mode_nxt;
    ax_r      <= ax_nxt;
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    rf_r      <= rf_nxt;
    cf_r      <= cf_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    k_r       <= k_nxt;
    xb0_r     <= xb0_nxt;
    xb1_r     <= xb1_nxt;
    yb0_r     <= yb0_nxt;
    yb1_r     <= yb1_nxt;
    bpl_r     <= bpl_nxt;
    q0_r      <= q0_nxt;
    r0_r      <= r0_nxt;
    accq_r    <= accq_nxt;
    accr_r    <= accr_nxt;
    rd_cnt_r  <= rd_cnt_nxt;
    ez_r      <= ez_nxt;
    zr_r      <= zr_nxt;
    lp_r      <= lp_nxt;
    prod_r    <= prod_nxt;
    res_r     <= res_nxt;
    out_val_r <= out_val_nxt;
  end

  assign busy           = (state_r != dlut_pkg::ST_IDLE);
  assign out_strobe     = out_strobe_r;
  assign out_duty_value = out_val_r;

endmodule
`default_nettype wire

FILE: hdl/dlut_ram.sv
`default_nettype none
module dlut_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hdl/dlut_div.sv
`default_nettype none
module dlut_div #(
  parameter int NW = 30,
  parameter int DW = 18
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic [NW-1:0]      quotient,
  output logic [DW-1:0]      remainder
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   sh;
  logic [DW:0]   diff;
  logic          ge;

  assign sh   = {rem_r, quo_r[NW-1]};
  assign ge   = sh >= {1'b0, den_r};
  assign diff = sh - {1'b0, den_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      den_nxt = divisor;
      cnt_nxt = CW'(NW);
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = ge ? diff[DW-1:0] : sh[DW-1:0];
      quo_nxt = {quo_r[NW-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire
